// File: src/oks_pkg.sv
// shared types, constants and helpers for the ordered key set core
// no dependencies; used by oks_occ_store and ordered_key_set_successor_core
`default_nettype none

package oks_pkg;

  // key universe and data word
  localparam int KEY_BITS  = 10;
  localparam int DATA_BITS = 32;
  localparam int UNIVERSE  = 1 << KEY_BITS;

  // occupancy words of 32 keys each, summary has one bit per word
  localparam int BIT_BITS  = 5;
  localparam int WORD_BITS = 1 << BIT_BITS;
  localparam int WIDX_BITS = KEY_BITS - BIT_BITS;
  localparam int NWORDS    = 1 << WIDX_BITS;

  localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
  localparam logic [KEY_BITS-1:0]  KEY_MAX   = {KEY_BITS{1'b1}};

  // request codes
  typedef logic [1:0] req_t;
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_LOOKUP = 2'd1;
  localparam req_t REQ_SUCC   = 2'd2;

  // occupancy store access request, one read and one write
  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [WIDX_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_word;
  } occ_req_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [BIT_BITS-1:0] low_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_BITS-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) n = BIT_BITS'(i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/oks_occ_store.sv
// occupancy word memory with registered read and per-word valid bits
// an unwritten word reads as zero; depends on oks_pkg
`default_nettype none

module oks_occ_store (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire oks_pkg::occ_req_t          req,
  output logic [oks_pkg::WORD_BITS-1:0]   rd_word
);

  logic [oks_pkg::WORD_BITS-1:0] mem [oks_pkg::NWORDS];
  logic [oks_pkg::NWORDS-1:0]    vld_r;
  logic [oks_pkg::WORD_BITS-1:0] rd_raw_r;
  logic                          rd_vld_r;

  // memory array, synchronous read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_word;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr];
    end
  end

  // valid bits stand in for the all-zero reset of the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) vld_r[req.wr_addr] <= 1'b1;
      if (req.rd_en) rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_raw_r : '0;

endmodule

`default_nettype wire

// File: src/ordered_key_set_successor_core.sv
// ordered key set with insert, lookup and successor over 1024 keys
// top level; depends on oks_pkg and oks_occ_store
`default_nettype none

// Usage
//   in_* channel carries one request per transaction: req_type, key and
//   entry_data (insert only). out_* channel returns one result per request,
//   in order, with found, result_key, result_data and the set's empty flag,
//   minimum and maximum after the request.
//   Both channels use valid/stall; a transaction completes when valid is
//   high and stall is low. in_stall is high while a request is in work.
//   Insert, misses and unknown codes finish after the occupancy word
//   read; lookup hit and successor in the same word add a data store
//   read; successor in a later word also reads the word the summary names.
//   One request is in work at a time, so a new request is accepted only
//   after the previous one finishes. The reads run in order: occupancy word,
//   then the next nonempty word found through the summary, then the data store.
//   A finished result waits in the output register while out_stall is high;
//   the request in work holds until that register is free, and a further
//   request can be accepted once the result has moved into it.
//   Reset (rst_n low, synchronous) empties the set at once; no clearing
//   pass is needed. Data of keys never inserted is never read.

module ordered_key_set_successor_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [oks_pkg::KEY_BITS-1:0]  in_key,
  input  wire logic [oks_pkg::DATA_BITS-1:0] in_entry_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [oks_pkg::KEY_BITS-1:0]       out_result_key,
  output logic [oks_pkg::DATA_BITS-1:0]      out_result_data,
  output logic                               out_set_empty,
  output logic [oks_pkg::KEY_BITS-1:0]       out_set_min,
  output logic [oks_pkg::KEY_BITS-1:0]       out_set_max
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_DATA
  } state_t;

  state_t                         state_r, state_nxt;
  oks_pkg::req_t                  req_r, req_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   key_r, key_nxt;
  logic [oks_pkg::DATA_BITS-1:0]  data_r, data_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   rkey_r, rkey_nxt;
  logic [oks_pkg::NWORDS-1:0]     summary_r, summary_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   min_r, min_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   max_r, max_nxt;
  logic                           any_r, any_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   out_key_r, out_key_nxt;
  logic [oks_pkg::DATA_BITS-1:0]  out_data_r, out_data_nxt;
  logic                           out_empty_r, out_empty_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   out_min_r, out_min_nxt;
  logic [oks_pkg::KEY_BITS-1:0]   out_max_r, out_max_nxt;

  oks_pkg::occ_req_t              occ_req;
  logic [oks_pkg::WORD_BITS-1:0]  occ_rd_word;

  logic [oks_pkg::DATA_BITS-1:0]  dat_mem [oks_pkg::UNIVERSE];
  logic [oks_pkg::DATA_BITS-1:0]  dat_rdata_r;
  logic                           dat_wr_en;
  logic                           dat_rd_en;
  logic [oks_pkg::KEY_BITS-1:0]   dat_rd_addr;

  logic                           out_free;
  logic [oks_pkg::KEY_BITS:0]     succ_in;
  logic [oks_pkg::KEY_BITS:0]     succ_q;
  logic [oks_pkg::WIDX_BITS-1:0]  succ_w;
  logic [oks_pkg::WIDX_BITS:0]    succ_w_next;
  logic [oks_pkg::WORD_BITS-1:0]  succ_bits;
  logic [oks_pkg::NWORDS-1:0]     sum_bits;
  logic [oks_pkg::WORD_BITS-1:0]  ins_bit;
  logic [oks_pkg::NWORDS-1:0]     ins_sum_bit;
  logic                           fin;

  // occupancy memory
  oks_occ_store u_occ (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (occ_req),
    .rd_word (occ_rd_word)
  );

  // data store, written on insert acceptance, read through a register
  always_ff @(posedge clk) begin
    if (dat_wr_en) begin
      dat_mem[in_key] <= in_entry_data;
    end
    if (dat_rd_en) begin
      dat_rdata_r <= dat_mem[dat_rd_addr];
    end
  end

  // successor address arithmetic
  assign succ_in     = {1'b0, in_key} + (oks_pkg::KEY_BITS+1)'(1);
  assign succ_q      = {1'b0, key_r} + (oks_pkg::KEY_BITS+1)'(1);
  assign succ_w      = succ_q[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS];
  assign succ_w_next = {1'b0, succ_w} + (oks_pkg::WIDX_BITS+1)'(1);
  assign succ_bits   = occ_rd_word & (oks_pkg::WORD_ONES << succ_q[oks_pkg::BIT_BITS-1:0]);
  assign sum_bits    = summary_r & (oks_pkg::WORD_ONES << succ_w_next);

  // insert masks
  assign ins_bit     = oks_pkg::WORD_BITS'(1) << key_r[oks_pkg::BIT_BITS-1:0];
  assign ins_sum_bit = oks_pkg::NWORDS'(1) << key_r[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS];

  assign out_free = !out_valid_r || !out_stall;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    data_nxt      = data_r;
    rkey_nxt      = rkey_r;
    summary_nxt   = summary_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_key_nxt   = out_key_r;
    out_data_nxt  = out_data_r;
    out_empty_nxt = out_empty_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    occ_req       = '0;
    dat_wr_en     = 1'b0;
    dat_rd_en     = 1'b0;
    dat_rd_addr   = key_r;
    fin           = 1'b0;

    // result taken by the receiver
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_req_type;
          key_nxt  = in_key;
          data_nxt = in_entry_data;
          occ_req.rd_en = 1'b1;
          if (in_req_type == oks_pkg::REQ_SUCC) begin
            occ_req.rd_addr = succ_in[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS];
          end else begin
            occ_req.rd_addr = in_key[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS];
          end
          dat_wr_en = (in_req_type == oks_pkg::REQ_INSERT);
          state_nxt = S_RD1;
        end
      end

      S_RD1: begin
        case (req_r)
          oks_pkg::REQ_INSERT: begin
            if (out_free) begin
              occ_req.wr_en   = 1'b1;
              occ_req.wr_addr = key_r[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS];
              occ_req.wr_word = occ_rd_word | ins_bit;
              summary_nxt     = summary_r | ins_sum_bit;
              any_nxt         = 1'b1;
              if (!any_r) begin
                min_nxt = key_r;
                max_nxt = key_r;
              end else begin
                if (key_r < min_r) min_nxt = key_r;
                if (key_r > max_r) max_nxt = key_r;
              end
              out_found_nxt = 1'b1;
              out_key_nxt   = key_r;
              out_data_nxt  = data_r;
              fin           = 1'b1;
            end
          end

          oks_pkg::REQ_LOOKUP: begin
            if (occ_rd_word[key_r[oks_pkg::BIT_BITS-1:0]]) begin
              dat_rd_en   = 1'b1;
              dat_rd_addr = key_r;
              rkey_nxt    = key_r;
              state_nxt   = S_DATA;
            end else if (out_free) begin
              out_found_nxt = 1'b0;
              out_key_nxt   = key_r;
              out_data_nxt  = '0;
              fin           = 1'b1;
            end
          end

          oks_pkg::REQ_SUCC: begin
            if (key_r != oks_pkg::KEY_MAX && succ_bits != '0) begin
              // successor in the same word
              rkey_nxt    = {succ_w, oks_pkg::low_bit(succ_bits)};
              dat_rd_en   = 1'b1;
              dat_rd_addr = {succ_w, oks_pkg::low_bit(succ_bits)};
              state_nxt   = S_DATA;
            end else if (key_r != oks_pkg::KEY_MAX && sum_bits != '0) begin
              // next nonempty word from the summary
              rkey_nxt        = {oks_pkg::low_bit(sum_bits), {oks_pkg::BIT_BITS{1'b0}}};
              occ_req.rd_en   = 1'b1;
              occ_req.rd_addr = oks_pkg::low_bit(sum_bits);
              state_nxt       = S_RD2;
            end else if (out_free) begin
              out_found_nxt = 1'b0;
              out_key_nxt   = '0;
              out_data_nxt  = '0;
              fin           = 1'b1;
            end
          end

          default: begin
            if (out_free) begin
              out_found_nxt = 1'b0;
              out_key_nxt   = key_r;
              out_data_nxt  = '0;
              fin           = 1'b1;
            end
          end
        endcase
      end

      S_RD2: begin
        rkey_nxt    = {rkey_r[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS],
                       oks_pkg::low_bit(occ_rd_word)};
        dat_rd_en   = 1'b1;
        dat_rd_addr = {rkey_r[oks_pkg::KEY_BITS-1:oks_pkg::BIT_BITS],
                       oks_pkg::low_bit(occ_rd_word)};
        state_nxt   = S_DATA;
      end

      S_DATA: begin
        if (out_free) begin
          out_found_nxt = 1'b1;
          out_key_nxt   = rkey_r;
          out_data_nxt  = dat_rdata_r;
          fin           = 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // load the set status with the result
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = !any_nxt;
      out_min_nxt   = min_nxt;
      out_max_nxt   = max_nxt;
      state_nxt     = S_IDLE;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      summary_r   <= '0;
      min_r       <= '0;
      max_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      summary_r   <= summary_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    key_r       <= key_nxt;
    data_r      <= data_nxt;
    rkey_r      <= rkey_nxt;
    out_found_r <= out_found_nxt;
    out_key_r   <= out_key_nxt;
    out_data_r  <= out_data_nxt;
    out_empty_r <= out_empty_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_result_key  = out_key_r;
  assign out_result_data = out_data_r;
  assign out_set_empty   = out_empty_r;
  assign out_set_min     = out_min_r;
  assign out_set_max     = out_max_r;

`ifndef ASSERT_OFF
  // an accepted transaction always starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RD1))
    else $error("accepted transaction did not start a read");

  // summary is nonzero exactly when the set holds a key
  a_summary_any: assert property (@(posedge clk) disable iff (!rst_n)
    ((summary_r != '0) == any_r))
    else $error("summary and presence flag disagree");

  // a nonempty set reports min no greater than max
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_empty_r) |-> (out_min_r <= out_max_r))
    else $error("reported minimum above maximum");

  // occupancy is written only when an insert finishes
  a_occ_write: assert property (@(posedge clk) disable iff (!rst_n)
    occ_req.wr_en |-> (state_r == S_RD1 && req_r == oks_pkg::REQ_INSERT && fin))
    else $error("occupancy write outside insert");
`endif

endmodule

`default_nettype wire
